// ----- hdl/ric_pkg.sv -----
// Shared constants and types for the raster interrupt register block.
package ric_pkg;

  localparam int CYCLES_PER_LINE = 63;
  localparam int LINES_PER_FRAME = 312;
  localparam int STALL_AMOUNT    = 40;
  localparam int COLOR_DEPTH     = 1024;

  localparam int LINE_W  = 9;
  localparam int CIL_W   = $clog2(CYCLES_PER_LINE + 64);
  localparam int CADDR_W = $clog2(COLOR_DEPTH);
  localparam int RADDR_W = 6;
  localparam int STALL_W = 6;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_REG_RD   = 3'd1;
  localparam logic [2:0] CMD_REG_WR   = 3'd2;
  localparam logic [2:0] CMD_COLOR_RD = 3'd3;
  localparam logic [2:0] CMD_COLOR_WR = 3'd4;
  localparam logic [2:0] CMD_TAKE     = 3'd5;

  localparam logic [RADDR_W-1:0] IDX_CTRL   = 6'h11;
  localparam logic [RADDR_W-1:0] IDX_LINE   = 6'h12;
  localparam logic [RADDR_W-1:0] IDX_STATUS = 6'h19;
  localparam logic [RADDR_W-1:0] IDX_ENABLE = 6'h1A;

  localparam logic [LINE_W-1:0] BAD_FIRST = 9'h030;
  localparam logic [LINE_W-1:0] BAD_LAST  = 9'h0F7;

  typedef struct packed {
    logic capture;
    logic exec;
    logic step;
    logic finish;
    logic clear;
  } ric_cmd_t;

  typedef struct packed {
    logic more_steps;
    logic clear_done;
    logic out_busy;
  } ric_stat_t;

endpackage

// ----- hdl/ric_ctrl.sv -----
// Sequencer for the raster interrupt register block.
module ric_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  input  ric_pkg::ric_stat_t stat,
  output ric_pkg::ric_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_STEP   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (stat.more_steps) begin
          cmd.step = 1'b1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the output slot to free up
        if (!stat.out_busy || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- hdl/ric_datapath.sv -----
// Raster counter, register file, colour store and result register.
module ric_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  ric_pkg::ric_cmd_t            cmd,
  output ric_pkg::ric_stat_t           stat,
  input  logic [2:0]                   command,
  input  logic [ric_pkg::RADDR_W-1:0]  reg_addr,
  input  logic [ric_pkg::CADDR_W-1:0]  color_addr,
  input  logic [7:0]                   write_data,
  input  logic [5:0]                   tick_cycles,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [7:0]                   read_data,
  output logic                         irq_out,
  output logic [ric_pkg::STALL_W-1:0]  stall_cycles
);

  localparam int RF_DEPTH = 2 ** ric_pkg::RADDR_W;

  // latched request
  logic [2:0]                  cmd_q;
  logic [ric_pkg::RADDR_W-1:0] ra_q;
  logic [ric_pkg::CADDR_W-1:0] ca_q;
  logic [7:0]                  wd_q;
  logic [5:0]                  tc_q;

  logic [7:0] rf_mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] rf_valid;
  logic [7:0] rf_rdata;
  logic       rf_rvalid;

  logic [3:0] color_mem [ric_pkg::COLOR_DEPTH];
  logic [3:0] cr_rdata;
  logic [ric_pkg::CADDR_W-1:0] clr_cnt;

  logic [7:0]                  ctrl;
  logic [3:0]                  status;
  logic [7:0]                  enable;
  logic [ric_pkg::LINE_W-1:0]  compare_line;
  logic [ric_pkg::STALL_W-1:0] pending;
  logic [ric_pkg::CIL_W-1:0]   cil;
  logic [ric_pkg::LINE_W-1:0]  line;
  logic                        crossed;

  logic [3:0] status_next;
  logic [7:0] enable_next;
  logic       is_reg_wr;
  logic       bad_line;
  logic [7:0] rd_value;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q <= command;
      ra_q  <= reg_addr;
      ca_q  <= color_addr;
      wd_q  <= write_data;
      tc_q  <= tick_cycles;
    end
  end

  assign is_reg_wr = cmd.finish && (cmd_q == ric_pkg::CMD_REG_WR);

  // register file: all but status is stored here; status, control and line reads come from flops
  always_ff @(posedge clk) begin
    if (is_reg_wr && ra_q != ric_pkg::IDX_STATUS) begin
      rf_mem[ra_q] <= wd_q;
    end
    if (cmd.exec) begin
      rf_rdata <= rf_mem[ra_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid  <= '0;
      rf_rvalid <= 1'b0;
    end else begin
      if (is_reg_wr && ra_q != ric_pkg::IDX_STATUS) begin
        rf_valid[ra_q] <= 1'b1;
      end
      if (cmd.exec) begin
        rf_rvalid <= rf_valid[ra_q];
      end
    end
  end

  // colour store, swept to zero after reset
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      color_mem[clr_cnt] <= 4'h0;
    end else if (cmd.finish && cmd_q == ric_pkg::CMD_COLOR_WR) begin
      color_mem[ca_q] <= wd_q[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cr_rdata <= color_mem[ca_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign stat.clear_done = (clr_cnt == ric_pkg::CADDR_W'(ric_pkg::COLOR_DEPTH - 1));
  assign stat.more_steps = (cmd_q == ric_pkg::CMD_TICK) &&
                           (cil >= ric_pkg::CIL_W'(ric_pkg::CYCLES_PER_LINE));
  assign stat.out_busy   = out_valid;

  always_comb begin
    status_next = status;
    if (cmd_q == ric_pkg::CMD_TICK && crossed && line == compare_line) begin
      status_next = status | 4'h1;
    end
    if (cmd_q == ric_pkg::CMD_REG_WR && ra_q == ric_pkg::IDX_STATUS) begin
      status_next = status & ~wd_q[3:0];
    end
    enable_next = enable;
    if (cmd_q == ric_pkg::CMD_REG_WR && ra_q == ric_pkg::IDX_ENABLE) begin
      enable_next = wd_q;
    end
  end

  assign bad_line = (cmd_q == ric_pkg::CMD_TICK) && crossed && ctrl[4] &&
                    (line >= ric_pkg::BAD_FIRST) && (line <= ric_pkg::BAD_LAST) &&
                    (line[2:0] == ctrl[2:0]);

  always_comb begin
    rd_value = 8'h00;
    case (cmd_q)
      ric_pkg::CMD_REG_RD: begin
        if (ra_q == ric_pkg::IDX_CTRL) begin
          rd_value = {line[8], ctrl[6:0]};
        end else if (ra_q == ric_pkg::IDX_LINE) begin
          rd_value = line[7:0];
        end else if (ra_q == ric_pkg::IDX_STATUS) begin
          rd_value = {|(status & enable[3:0]), 3'b000, status};
        end else begin
          rd_value = rf_rvalid ? rf_rdata : 8'h00;
        end
      end
      ric_pkg::CMD_COLOR_RD: rd_value = {4'hF, cr_rdata};
      default:               rd_value = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl         <= '0;
      status       <= '0;
      enable       <= '0;
      compare_line <= '0;
      pending      <= '0;
      cil          <= '0;
      line         <= '0;
      crossed      <= 1'b0;
    end else begin
      if (cmd.exec && cmd_q == ric_pkg::CMD_TICK) begin
        cil     <= cil + ric_pkg::CIL_W'(tc_q);
        crossed <= 1'b0;
      end
      // one line boundary per cycle
      if (cmd.step) begin
        cil     <= cil - ric_pkg::CIL_W'(ric_pkg::CYCLES_PER_LINE);
        crossed <= 1'b1;
        if (line == ric_pkg::LINE_W'(ric_pkg::LINES_PER_FRAME - 1)) begin
          line <= '0;
        end else begin
          line <= line + 1'b1;
        end
      end
      if (cmd.finish) begin
        status <= status_next;
        enable <= enable_next;
        if (cmd_q == ric_pkg::CMD_REG_WR && ra_q == ric_pkg::IDX_CTRL) begin
          ctrl            <= wd_q;
          compare_line[8] <= wd_q[7];
        end
        if (cmd_q == ric_pkg::CMD_REG_WR && ra_q == ric_pkg::IDX_LINE) begin
          compare_line[7:0] <= wd_q;
        end
        if (bad_line) begin
          pending <= ric_pkg::STALL_W'(ric_pkg::STALL_AMOUNT);
        end else if (cmd_q == ric_pkg::CMD_TAKE) begin
          pending <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_data    <= rd_value;
      irq_out      <= |(status_next & enable_next[3:0]);
      stall_cycles <= (cmd_q == ric_pkg::CMD_TAKE) ? pending : '0;
    end
  end

  a_cil_in_line: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> cil < ric_pkg::CIL_W'(ric_pkg::CYCLES_PER_LINE))
    else $error("raster cycle left outside the line at finish");

  a_line_in_frame: assert property (@(posedge clk) disable iff (rst)
    line < ric_pkg::LINE_W'(ric_pkg::LINES_PER_FRAME))
    else $error("raster line beyond frame");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result register overwritten before taken");

  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && cmd_q == ric_pkg::CMD_TAKE) |=> pending == '0)
    else $error("stall not cleared after take");

endmodule

// ----- hdl/raster_irq_register_block.sv -----
// Top level of the raster interrupt register block.
//
// Requests arrive on the s_axis channel: each is a tick, a register read or
// write, a colour store read or write, or a take-stall request. Every request
// gives exactly one result on m_axis (read data, interrupt level, stall).
// After reset the colour store is swept to zero, one cell a cycle, with
// s_tready low until the sweep is done; registers and counters clear at once.
// m_tvalid rises after the memory read, line step check and result load; a
// tick also spends a step for each line boundary it crosses, since the line
// counter steps one line per cycle.
// One request is worked on at a time: a new request is accepted only once the
// sequencer has loaded the result of the last one, after the registered
// memory reads. The result register holds its value while m_tready is low;
// the next request is accepted meanwhile and waits in its final step until
// the result slot frees up.
module raster_irq_register_block (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[2:0], reg_addr[8:3], color_addr[18:9], write_data[26:19],
  // tick_cycles[32:27], zero fill [39:33]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], irq_out[8], stall_cycles[14:9], zero fill [15]
  output logic [15:0] m_tdata
);

  ric_pkg::ric_cmd_t  cmd;
  ric_pkg::ric_stat_t stat;

  logic [7:0]                  read_data;
  logic                        irq_out;
  logic [ric_pkg::STALL_W-1:0] stall_cycles;

  ric_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ric_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (s_tdata[2:0]),
    .reg_addr     (s_tdata[8:3]),
    .color_addr   (s_tdata[18:9]),
    .write_data   (s_tdata[26:19]),
    .tick_cycles  (s_tdata[32:27]),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .read_data    (read_data),
    .irq_out      (irq_out),
    .stall_cycles (stall_cycles)
  );

  assign m_tdata = {1'b0, stall_cycles, irq_out, read_data};

endmodule
